// File: rtl/epc_pkg.sv
// epc_pkg: shared types and constants for the ethernet packet classifier
// no dependencies; used by epc_out_if and every rtl module
package epc_pkg;

    typedef logic [3:0] class_t;

    localparam class_t CLS_ARP      = 4'd0;
    localparam class_t CLS_ICMP     = 4'd1;
    localparam class_t CLS_ICMP6    = 4'd2;
    localparam class_t CLS_TCP      = 4'd3;
    localparam class_t CLS_HTTP     = 4'd4;
    localparam class_t CLS_UDP      = 4'd5;
    localparam class_t CLS_IP4_OTH  = 4'd6;
    localparam class_t CLS_IP6_OTH  = 4'd7;
    localparam class_t CLS_OTHER    = 4'd8;
    localparam class_t CLS_TRUNC    = 4'd9;

    localparam int NUM_COUNTERS = 10;
    localparam class_t TOTAL_IDX = 4'd9;
    localparam int OUT_COUNT_W = 32;

    localparam logic [15:0] ETH_ARP  = 16'h0806;
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86dd;

    localparam logic [7:0] PR_ICMP  = 8'h01;
    localparam logic [7:0] PR_ICMP6 = 8'h3a;
    localparam logic [7:0] PR_TCP   = 8'h06;
    localparam logic [7:0] PR_UDP   = 8'h11;

    localparam logic [15:0] TYPE_HI_POS   = 16'd12;
    localparam logic [15:0] TYPE_LO_POS   = 16'd13;
    localparam logic [15:0] MAC_LEN       = 16'd14;
    localparam logic [15:0] IP4_PROTO_POS = 16'd23;
    localparam logic [15:0] IP6_PROTO_POS = 16'd20;
    localparam logic [5:0]  IPV6_LEN      = 6'd40;
    localparam logic [15:0] HTTP_RESET    = 16'd80;

    typedef struct packed {
        class_t      packet_class;
        logic        recognized;
        logic [15:0] ether_type;
        logic [7:0]  transport_proto;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } hdr_res_t;

    typedef struct packed {
        logic   done;
        logic   is4;
        logic   is6;
        class_t cls;
    } count_req_t;

endpackage

// File: rtl/epc_if.sv
// epc_in_if and epc_out_if: valid/ready channels for frame words and results
// depends on epc_pkg for field types
interface epc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface epc_out_if;
    logic                valid;
    logic                ready;
    epc_pkg::class_t     packet_class;
    logic                recognized;
    logic [15:0]         ether_type;
    logic [7:0]          transport_proto;
    logic [15:0]         source_port;
    logic [15:0]         dest_port;
    logic [31:0]         total_count;
    logic [31:0]         class_count;

    modport source (
        output valid, output packet_class, output recognized, output ether_type,
        output transport_proto, output source_port, output dest_port,
        output total_count, output class_count, input ready
    );
    modport sink (
        input valid, input packet_class, input recognized, input ether_type,
        input transport_proto, input source_port, input dest_port,
        input total_count, input class_count, output ready
    );
endinterface

// File: rtl/ethernet_packet_classifier.sv
// ethernet_packet_classifier: top level with input word register and result register
// depends on epc_pkg, epc_if, epc_parser and epc_counters
//
// Accepts one frame word per clock with no gaps needed between frames. Each
// accepted word is held in an input register and from there updates the
// position-indexed header capture; on the word marked as frame end the class,
// header fields and updated counters land in the result register. Throughput
// is one word per cycle, set by the capture registers that take one word each
// clock; it drops only while a finished result is held by a stalled consumer
// and the next frame-end word waits behind it. http_port resets to 80; the user
// must write it through cfg_we/cfg_data only while no frame is in flight, which
// the block itself does not enforce. Counters are COUNT_WIDTH bits wide and
// wrap; the low 32 bits are reported.
module ethernet_packet_classifier #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    epc_in_if.sink           frame_in,
    epc_out_if.source        result_out,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_data
);

    logic [15:0] http_port_reg;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_end_reg;
    logic       s1_fire;
    logic       res_free;

    epc_pkg::hdr_res_t   hdr;
    epc_pkg::count_req_t req;
    logic [31:0]         total_count;
    logic [31:0]         class_count;

    logic                res_valid_reg;
    epc_pkg::hdr_res_t   res_hdr_reg;
    logic [31:0]         res_total_reg;
    logic [31:0]         res_class_reg;

    assign res_free       = !res_valid_reg || result_out.ready;
    assign s1_fire        = s1_valid_reg && (!s1_end_reg || res_free);
    assign frame_in.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            http_port_reg <= epc_pkg::HTTP_RESET;
        end
        else if (cfg_we)
        begin
            http_port_reg <= cfg_data;
        end
    end

    // input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (frame_in.valid && frame_in.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_in.valid && frame_in.ready)
        begin
            s1_byte_reg <= frame_in.frame_byte;
            s1_end_reg  <= frame_in.frame_end;
        end
    end

    epc_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_fire),
        .frame_byte (s1_byte_reg),
        .frame_end  (s1_end_reg),
        .http_port  (http_port_reg),
        .res        (hdr),
        .req        (req)
    );

    epc_counters #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_counters (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .total_count (total_count),
        .class_count (class_count)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_end_reg)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_end_reg)
        begin
            res_hdr_reg   <= hdr;
            res_total_reg <= total_count;
            res_class_reg <= class_count;
        end
    end

    assign result_out.valid           = res_valid_reg;
    assign result_out.packet_class    = res_hdr_reg.packet_class;
    assign result_out.recognized      = res_hdr_reg.recognized;
    assign result_out.ether_type      = res_hdr_reg.ether_type;
    assign result_out.transport_proto = res_hdr_reg.transport_proto;
    assign result_out.source_port     = res_hdr_reg.source_port;
    assign result_out.dest_port       = res_hdr_reg.dest_port;
    assign result_out.total_count     = res_total_reg;
    assign result_out.class_count     = res_class_reg;

endmodule

// File: rtl/epc_parser.sv
// epc_parser: position-indexed header capture and frame-end classification
// depends on epc_pkg
module epc_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          frame_byte,
    input  logic                frame_end,
    input  logic [15:0]         http_port,
    output epc_pkg::hdr_res_t   res,
    output epc_pkg::count_req_t req
);

    logic [15:0] pos_reg, pos_next;
    logic [15:0] type_reg, type_next;
    logic [5:0]  nhb_reg, nhb_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] sport_reg, sport_next;
    logic [15:0] dport_reg, dport_next;

    logic            is4, is6, ip, in_ip;
    logic [15:0]     proto_pos;
    logic [15:0]     t_pos;
    logic [15:0]     t3_pos;
    logic [15:0]     port_off;
    epc_pkg::class_t cls;
    logic            is_l4;

    always_comb
    begin
        type_next = type_reg;
        if (pos_reg == epc_pkg::TYPE_HI_POS)
        begin
            type_next = {frame_byte, type_reg[7:0]};
        end
        else if (pos_reg == epc_pkg::TYPE_LO_POS)
        begin
            type_next = {type_reg[15:8], frame_byte};
        end

        is4   = (type_next == epc_pkg::ETH_IPV4);
        is6   = (type_next == epc_pkg::ETH_IPV6);
        ip    = is4 | is6;
        in_ip = ip && (pos_reg >= epc_pkg::MAC_LEN);

        nhb_next = nhb_reg;
        if (in_ip && pos_reg == epc_pkg::MAC_LEN)
        begin
            nhb_next = is4 ? {frame_byte[3:0], 2'b00} : epc_pkg::IPV6_LEN;
        end

        proto_pos  = is4 ? epc_pkg::IP4_PROTO_POS : epc_pkg::IP6_PROTO_POS;
        proto_next = proto_reg;
        if (in_ip && pos_reg == proto_pos)
        begin
            proto_next = frame_byte;
        end

        t_pos      = epc_pkg::MAC_LEN + {10'd0, nhb_next};
        t3_pos     = t_pos + 16'd3;
        port_off   = pos_reg - t_pos;
        sport_next = sport_reg;
        dport_next = dport_reg;
        if (in_ip && pos_reg >= t_pos && port_off < 16'd4)
        begin
            unique case (port_off[1:0])
                2'd0: sport_next = {frame_byte, sport_reg[7:0]};
                2'd1: sport_next = {sport_reg[15:8], frame_byte};
                2'd2: dport_next = {frame_byte, dport_reg[7:0]};
                2'd3: dport_next = {dport_reg[15:8], frame_byte};
                default: sport_next = sport_reg;
            endcase
        end

        // classification on the last word of a frame
        priority if (pos_reg < epc_pkg::TYPE_LO_POS)
        begin
            cls = epc_pkg::CLS_TRUNC;
        end
        else if (type_next == epc_pkg::ETH_ARP)
        begin
            cls = epc_pkg::CLS_ARP;
        end
        else if (ip)
        begin
            if (pos_reg < proto_pos)
            begin
                cls = epc_pkg::CLS_TRUNC;
            end
            else if (proto_next == epc_pkg::PR_TCP || proto_next == epc_pkg::PR_UDP)
            begin
                if (pos_reg < t3_pos)
                begin
                    cls = epc_pkg::CLS_TRUNC;
                end
                else if (proto_next == epc_pkg::PR_UDP)
                begin
                    cls = epc_pkg::CLS_UDP;
                end
                else if (sport_next == http_port || dport_next == http_port)
                begin
                    cls = epc_pkg::CLS_HTTP;
                end
                else
                begin
                    cls = epc_pkg::CLS_TCP;
                end
            end
            else if (is4)
            begin
                cls = (proto_next == epc_pkg::PR_ICMP) ? epc_pkg::CLS_ICMP
                                                       : epc_pkg::CLS_IP4_OTH;
            end
            else
            begin
                cls = (proto_next == epc_pkg::PR_ICMP6) ? epc_pkg::CLS_ICMP6
                                                        : epc_pkg::CLS_IP6_OTH;
            end
        end
        else
        begin
            cls = epc_pkg::CLS_OTHER;
        end

        is_l4 = (cls == epc_pkg::CLS_TCP) || (cls == epc_pkg::CLS_HTTP)
             || (cls == epc_pkg::CLS_UDP);

        res.packet_class    = cls;
        res.recognized      = (cls <= epc_pkg::CLS_UDP);
        res.ether_type      = type_next;
        res.transport_proto = (ip && cls != epc_pkg::CLS_TRUNC) ? proto_next : 8'd0;
        res.source_port     = is_l4 ? sport_next : 16'd0;
        res.dest_port       = is_l4 ? dport_next : 16'd0;

        req.done = step && frame_end;
        req.is4  = is4;
        req.is6  = is6;
        req.cls  = cls;

        pos_next = (pos_reg == 16'hffff) ? pos_reg : pos_reg + 16'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            type_reg  <= '0;
            nhb_reg   <= '0;
            proto_reg <= '0;
            sport_reg <= '0;
            dport_reg <= '0;
        end
        else if (step)
        begin
            if (frame_end)
            begin
                pos_reg   <= '0;
                type_reg  <= '0;
                nhb_reg   <= '0;
                proto_reg <= '0;
                sport_reg <= '0;
                dport_reg <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                type_reg  <= type_next;
                nhb_reg   <= nhb_next;
                proto_reg <= proto_next;
                sport_reg <= sport_next;
                dport_reg <= dport_next;
            end
        end
    end

endmodule

// File: rtl/epc_counters.sv
// epc_counters: per-class and total frame counters, wrapping
// depends on epc_pkg
module epc_counters #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  epc_pkg::count_req_t req,
    output logic [31:0]         total_count,
    output logic [31:0]         class_count
);

    localparam int EXT_W = (COUNT_WIDTH > epc_pkg::OUT_COUNT_W) ? COUNT_WIDTH
                                                                : epc_pkg::OUT_COUNT_W;

    logic [COUNT_WIDTH-1:0] cnt_reg [epc_pkg::NUM_COUNTERS];
    logic [COUNT_WIDTH-1:0] total_inc;
    logic [COUNT_WIDTH-1:0] class_inc;
    logic [EXT_W-1:0]       total_ext;
    logic [EXT_W-1:0]       class_ext;
    logic                   trunc;

    assign trunc     = (req.cls == epc_pkg::CLS_TRUNC);
    assign total_inc = cnt_reg[epc_pkg::TOTAL_IDX] + 1'b1;
    assign class_inc = cnt_reg[req.cls] + 1'b1;
    assign total_ext = EXT_W'(total_inc);
    assign class_ext = trunc ? '0 : EXT_W'(class_inc);
    assign total_count = total_ext[31:0];
    assign class_count = class_ext[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < epc_pkg::NUM_COUNTERS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (req.done)
        begin
            for (int i = 0; i < epc_pkg::NUM_COUNTERS; i++)
            begin
                if (i == int'(epc_pkg::TOTAL_IDX))
                begin
                    cnt_reg[i] <= cnt_reg[i] + 1'b1;
                end
                else if (!trunc && (int'(req.cls) == i
                         || (i == int'(epc_pkg::CLS_IP4_OTH) && req.is4)
                         || (i == int'(epc_pkg::CLS_IP6_OTH) && req.is6)))
                begin
                    cnt_reg[i] <= cnt_reg[i] + 1'b1;
                end
            end
        end
    end

endmodule

// File: bench/tb_ethernet_packet_classifier.sv
`timescale 1ns / 1ps
// tb_ethernet_packet_classifier: self-checking bench for the ethernet packet classifier
// depends on epc_pkg, epc_if and the ethernet_packet_classifier rtl
module tb_ethernet_packet_classifier;

    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        epc_pkg::class_t cls;
        logic            rec;
        logic [15:0]     etype;
        logic [7:0]      proto;
        logic [15:0]     sport;
        logic [15:0]     dport;
        logic [31:0]     total;
        logic [31:0]     count;
    } hdr_report_t;

    typedef struct packed {
        logic [15:0] etype;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] len;
        logic        typed;
        hdr_report_t want;
    } frame_spec_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;

    epc_in_if  frame_in();
    epc_out_if result_out();

    ethernet_packet_classifier dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_in   (frame_in),
        .result_out (result_out),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data)
    );

    // classifier state as the bench sees it
    logic [15:0] cur_offset;
    logic [15:0] cur_type;
    logic [5:0]  cur_hdr_len;
    logic [7:0]  cur_proto;
    logic [15:0] cur_sport;
    logic [15:0] cur_dport;
    logic [31:0] frame_tally [epc_pkg::NUM_COUNTERS];
    logic [15:0] http_sel;

    hdr_report_t pending_reports[$];
    hdr_report_t typed_reports[$];
    bit          typed_flags[$];
    frame_spec_t directed_rows[$];

    int errors;
    int words_seen;
    int frames_seen;
    int stall_cycles;
    int send_idle;
    int recv_idle;

    always #5 clk = ~clk;

    always @(negedge clk) result_out.ready <= ($urandom_range(99) >= recv_idle);

    task automatic classify_word(input logic [7:0] b, input logic last,
                                 output hdr_report_t rep);
        logic [15:0]     pos;
        logic [15:0]     hdr_end;
        logic [15:0]     proto_at;
        logic            is4;
        logic            is6;
        epc_pkg::class_t cls;
        epc_pkg::class_t ip_slot;
        pos = cur_offset;
        rep = '0;
        if (pos == epc_pkg::TYPE_HI_POS)
            cur_type[15:8] = b;
        else if (pos == epc_pkg::TYPE_LO_POS)
            cur_type[7:0] = b;
        is4 = (cur_type == epc_pkg::ETH_IPV4);
        is6 = (cur_type == epc_pkg::ETH_IPV6);
        proto_at = is4 ? epc_pkg::IP4_PROTO_POS : epc_pkg::IP6_PROTO_POS;
        if (pos >= epc_pkg::MAC_LEN && (is4 || is6))
        begin
            if (pos == epc_pkg::MAC_LEN)
                cur_hdr_len = is4 ? {b[3:0], 2'b00} : epc_pkg::IPV6_LEN;
            if (pos == proto_at)
                cur_proto = b;
            hdr_end = epc_pkg::MAC_LEN + {10'd0, cur_hdr_len};
            if (pos == hdr_end)
                cur_sport[15:8] = b;
            else if (pos == hdr_end + 16'd1)
                cur_sport[7:0] = b;
            else if (pos == hdr_end + 16'd2)
                cur_dport[15:8] = b;
            else if (pos == hdr_end + 16'd3)
                cur_dport[7:0] = b;
        end
        if (!last)
        begin
            if (cur_offset != 16'hffff)
                cur_offset = cur_offset + 16'd1;
        end
        else
        begin
            frame_tally[epc_pkg::TOTAL_IDX] += 1;
            hdr_end = epc_pkg::MAC_LEN + {10'd0, cur_hdr_len};
            cls = epc_pkg::CLS_TRUNC;
            if (pos < epc_pkg::TYPE_LO_POS)
                cls = epc_pkg::CLS_TRUNC;
            else if (cur_type == epc_pkg::ETH_ARP)
                cls = epc_pkg::CLS_ARP;
            else if (is4 || is6)
            begin
                if (pos >= proto_at)
                begin
                    if (cur_proto == epc_pkg::PR_TCP || cur_proto == epc_pkg::PR_UDP)
                    begin
                        if (pos >= hdr_end + 16'd3)
                        begin
                            if (cur_proto == epc_pkg::PR_UDP)
                                cls = epc_pkg::CLS_UDP;
                            else if (cur_sport == http_sel || cur_dport == http_sel)
                                cls = epc_pkg::CLS_HTTP;
                            else
                                cls = epc_pkg::CLS_TCP;
                        end
                    end
                    else if (is4)
                        cls = (cur_proto == epc_pkg::PR_ICMP) ? epc_pkg::CLS_ICMP
                                                              : epc_pkg::CLS_IP4_OTH;
                    else
                        cls = (cur_proto == epc_pkg::PR_ICMP6) ? epc_pkg::CLS_ICMP6
                                                               : epc_pkg::CLS_IP6_OTH;
                end
            end
            else
                cls = epc_pkg::CLS_OTHER;

            rep.cls = cls;
            rep.rec = (cls <= epc_pkg::CLS_UDP);
            rep.etype = cur_type;
            rep.total = frame_tally[epc_pkg::TOTAL_IDX];
            if (cls != epc_pkg::CLS_TRUNC)
            begin
                if (is4 || is6)
                begin
                    ip_slot = is4 ? epc_pkg::CLS_IP4_OTH : epc_pkg::CLS_IP6_OTH;
                    frame_tally[ip_slot] += 1;
                    rep.count = frame_tally[ip_slot];
                    if (cls != epc_pkg::CLS_IP4_OTH && cls != epc_pkg::CLS_IP6_OTH)
                    begin
                        frame_tally[cls] += 1;
                        rep.count = frame_tally[cls];
                    end
                    rep.proto = cur_proto;
                    if (cls >= epc_pkg::CLS_TCP && cls <= epc_pkg::CLS_UDP)
                    begin
                        rep.sport = cur_sport;
                        rep.dport = cur_dport;
                    end
                end
                else
                begin
                    frame_tally[cls] += 1;
                    rep.count = frame_tally[cls];
                end
            end
            cur_offset = '0;
            cur_type = '0;
            cur_hdr_len = '0;
            cur_proto = '0;
            cur_sport = '0;
            cur_dport = '0;
        end
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : handshake_monitor
        hdr_report_t got;
        hdr_report_t want;
        hdr_report_t seen;
        bit          typed;
        if (rst_n)
        begin
            if (result_out.valid && result_out.ready)
            begin
                got = {result_out.packet_class, result_out.recognized, result_out.ether_type,
                       result_out.transport_proto, result_out.source_port, result_out.dest_port,
                       result_out.total_count, result_out.class_count};
                if (pending_reports.size() == 0)
                begin
                    $display("%0t: result word with nothing expected, actual %0h", $time, got);
                    errors++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("packet_class", want.cls, got.cls);
                    check_field("recognized", want.rec, got.rec);
                    check_field("ether_type", want.etype, got.etype);
                    check_field("transport_proto", want.proto, got.proto);
                    check_field("source_port", want.sport, got.sport);
                    check_field("dest_port", want.dport, got.dport);
                    check_field("total_count", want.total, got.total);
                    check_field("class_count", want.count, got.count);
                end
            end
            if (frame_in.valid && frame_in.ready)
            begin
                classify_word(frame_in.frame_byte, frame_in.frame_end, seen);
                words_seen++;
                if (frame_in.frame_end)
                begin
                    typed = typed_flags.pop_front();
                    want = typed_reports.pop_front();
                    pending_reports.push_back(typed ? want : seen);
                    frames_seen++;
                end
            end
            if ((frame_in.valid && frame_in.ready) || (result_out.valid && result_out.ready)
                || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("ethernet_packet_classifier verification failed");
                $finish;
            end
        end
    end

    function automatic frame_spec_t frame_row(
        input logic [15:0] etype, input logic [3:0] ihl, input logic [7:0] proto,
        input logic [15:0] sport, input logic [15:0] dport, input int len,
        input bit typed, input epc_pkg::class_t w_cls, input logic [15:0] w_type,
        input logic [31:0] w_total, input logic [31:0] w_count);
        frame_spec_t s;
        s = '0;
        s.etype = etype;
        s.ihl = ihl;
        s.proto = proto;
        s.sport = sport;
        s.dport = dport;
        s.len = len;
        s.typed = typed;
        s.want.cls = w_cls;
        s.want.rec = (w_cls <= epc_pkg::CLS_UDP);
        s.want.etype = w_type;
        s.want.total = w_total;
        s.want.count = w_count;
        return s;
    endfunction

    function automatic frame_spec_t random_frame();
        frame_spec_t s;
        int          pick;
        int          full;
        s = '0;
        s.sport = 16'($urandom);
        s.dport = 16'($urandom);
        s.ihl = 4'($urandom);
        s.proto = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 10)
            s.etype = epc_pkg::ETH_ARP;
        else if (pick < 80)
        begin
            s.etype = (pick < 50) ? epc_pkg::ETH_IPV4 : epc_pkg::ETH_IPV6;
            if (s.etype == epc_pkg::ETH_IPV4)
            begin
                pick = $urandom_range(99);
                if (pick < 80)
                    s.ihl = 4'd5;
                else if (pick < 95)
                    s.ihl = 4'($urandom_range(5, 15));
                else
                    s.ihl = 4'($urandom_range(0, 4));
            end
            case ($urandom_range(9))
                0, 1, 2: s.proto = epc_pkg::PR_TCP;
                3, 4, 5: s.proto = epc_pkg::PR_UDP;
                6:       s.proto = (s.etype == epc_pkg::ETH_IPV4) ? epc_pkg::PR_ICMP
                                                                  : epc_pkg::PR_ICMP6;
                7:       s.proto = (s.etype == epc_pkg::ETH_IPV4) ? epc_pkg::PR_ICMP6
                                                                  : epc_pkg::PR_ICMP;
                default: ;
            endcase
            pick = $urandom_range(99);
            if (pick < 30)
                s.dport = http_sel;
            else if (pick < 45)
                s.sport = http_sel;
            full = epc_pkg::MAC_LEN
                 + ((s.etype == epc_pkg::ETH_IPV4) ? 4 * s.ihl : epc_pkg::IPV6_LEN) + 4;
            s.len = ($urandom_range(99) < 85) ? full + $urandom_range(0, 24)
                                              : $urandom_range(1, full);
        end
        else if (pick < 90)
        begin
            case ($urandom_range(3))
                0:       s.etype = 16'h8100;
                1:       s.etype = 16'h0000;
                2:       s.etype = 16'hffff;
                default: s.etype = 16'($urandom);
            endcase
        end
        else
        begin
            s.etype = 16'($urandom);
            s.len = $urandom_range(1, 13);
        end
        if (s.len == 0)
            s.len = ($urandom_range(9) == 0) ? $urandom_range(1, 14) : $urandom_range(14, 60);
        return s;
    endfunction

    task automatic send_word(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle)
        begin
            frame_in.valid <= 1'b0;
            @(negedge clk);
        end
        frame_in.valid <= 1'b1;
        frame_in.frame_byte <= b;
        frame_in.frame_end <= last;
        @(posedge clk);
        while (!frame_in.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_frame(input frame_spec_t s);
        logic [7:0]  fb[$];
        logic [31:0] ports;
        int          n;
        int          i;
        int          hdr_end;
        int          proto_at;
        logic        is4;
        logic        isip;
        n = int'(s.len);
        is4 = (s.etype == epc_pkg::ETH_IPV4);
        isip = is4 || (s.etype == epc_pkg::ETH_IPV6);
        ports = {s.sport, s.dport};
        for (i = 0; i < n; i++)
            fb.push_back(8'($urandom));
        if (isip)
        begin
            hdr_end = epc_pkg::MAC_LEN + (is4 ? 4 * s.ihl : epc_pkg::IPV6_LEN);
            for (i = 0; i < 4; i++)
                if (hdr_end + i < n)
                    fb[hdr_end + i] = ports[31 - 8 * i -: 8];
        end
        if (n > 12)
            fb[12] = s.etype[15:8];
        if (n > 13)
            fb[13] = s.etype[7:0];
        if (isip)
        begin
            if (n > 14)
                fb[14] = {(is4 ? 4'h4 : 4'h6), s.ihl};
            proto_at = is4 ? epc_pkg::IP4_PROTO_POS : epc_pkg::IP6_PROTO_POS;
            if (proto_at < n)
                fb[proto_at] = s.proto;
        end
        typed_flags.push_back(s.typed);
        typed_reports.push_back(s.want);
        for (i = 0; i < n; i++)
            send_word(fb[i], i == n - 1);
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input logic [15:0] port_value);
        int words_at_start;
        int frames_in_phase;
        frame_in.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= port_value;
        http_sel = port_value;
        @(negedge clk);
        cfg_we <= 1'b0;
        send_idle = s_pct;
        recv_idle = r_pct;
        words_at_start = words_seen;
        frames_in_phase = 0;
        while (words_seen - words_at_start < 100 || frames_in_phase < 2)
        begin
            // hold the sender until the result stream drains
            if (frames_in_phase == 1)
            begin
                frame_in.valid <= 1'b0;
                while (pending_reports.size() != 0)
                    @(negedge clk);
                @(negedge clk);
            end
            send_frame(random_frame());
            frames_in_phase++;
        end
    endtask

    initial
    begin : stimulus
        int i;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        frame_in.valid = 1'b0;
        frame_in.frame_byte = '0;
        frame_in.frame_end = 1'b0;
        result_out.ready = 1'b0;
        errors = 0;
        words_seen = 0;
        frames_seen = 0;
        stall_cycles = 0;
        send_idle = 34;
        recv_idle = 55;
        http_sel = epc_pkg::HTTP_RESET;
        cur_offset = '0;
        cur_type = '0;
        cur_hdr_len = '0;
        cur_proto = '0;
        cur_sport = '0;
        cur_dport = '0;
        for (i = 0; i < epc_pkg::NUM_COUNTERS; i++)
            frame_tally[i] = '0;

        // directed frames with the http port at its reset value
        directed_rows.push_back(frame_row(epc_pkg::ETH_ARP, 4'd0, 8'h00, 16'd0, 16'd0, 14,
            1'b1, epc_pkg::CLS_ARP, epc_pkg::ETH_ARP, 32'd1, 32'd1));
        directed_rows.push_back(frame_row(epc_pkg::ETH_ARP, 4'd0, 8'h00, 16'd0, 16'd0, 5,
            1'b1, epc_pkg::CLS_TRUNC, 16'h0000, 32'd2, 32'd0));
        directed_rows.push_back(frame_row(epc_pkg::ETH_ARP, 4'd0, 8'h00, 16'd0, 16'd0, 13,
            1'b1, epc_pkg::CLS_TRUNC, 16'h0800, 32'd3, 32'd0));
        directed_rows.push_back(frame_row(epc_pkg::ETH_IPV4, 4'd5, epc_pkg::PR_TCP,
            16'd1234, 16'd80, 38, 1'b0, epc_pkg::CLS_ARP, '0, '0, '0));
        directed_rows.push_back(frame_row(epc_pkg::ETH_IPV4, 4'd5, epc_pkg::PR_TCP,
            16'd80, 16'd0, 38, 1'b0, epc_pkg::CLS_ARP, '0, '0, '0));
        directed_rows.push_back(frame_row(epc_pkg::ETH_IPV4, 4'd5, epc_pkg::PR_TCP,
            16'd0, 16'hffff, 38, 1'b0, epc_pkg::CLS_ARP, '0, '0, '0));
        directed_rows.push_back(frame_row(epc_pkg::ETH_IPV4, 4'd5, epc_pkg::PR_UDP,
            16'hffff, 16'd80, 38, 1'b0, epc_pkg::CLS_ARP, '0, '0, '0));
        directed_rows.push_back(frame_row(epc_pkg::ETH_IPV4, 4'd5, epc_pkg::PR_ICMP,
            16'd0, 16'd0, 24, 1'b0, epc_pkg::CLS_ARP, '0, '0, '0));
        directed_rows.push_back(frame_row(epc_pkg::ETH_IPV4, 4'd5, 8'hff,
            16'd0, 16'd0, 24, 1'b0, epc_pkg::CLS_ARP, '0, '0, '0));
        directed_rows.push_back(frame_row(epc_pkg::ETH_IPV4, 4'd5, epc_pkg::PR_TCP,
            16'd5, 16'd6, 37, 1'b1, epc_pkg::CLS_TRUNC, epc_pkg::ETH_IPV4, 32'd10, 32'd0));
        directed_rows.push_back(frame_row(epc_pkg::ETH_IPV4, 4'd0, epc_pkg::PR_TCP,
            16'd80, 16'd80, 24, 1'b0, epc_pkg::CLS_ARP, '0, '0, '0));
        directed_rows.push_back(frame_row(epc_pkg::ETH_IPV4, 4'd15, epc_pkg::PR_UDP,
            16'h1234, 16'h5678, 78, 1'b0, epc_pkg::CLS_ARP, '0, '0, '0));
        directed_rows.push_back(frame_row(epc_pkg::ETH_IPV4, 4'd4, epc_pkg::PR_UDP,
            16'h0a0b, 16'h0c0d, 34, 1'b0, epc_pkg::CLS_ARP, '0, '0, '0));
        directed_rows.push_back(frame_row(epc_pkg::ETH_IPV6, 4'd0, epc_pkg::PR_ICMP6,
            16'd0, 16'd0, 21, 1'b0, epc_pkg::CLS_ARP, '0, '0, '0));
        directed_rows.push_back(frame_row(epc_pkg::ETH_IPV6, 4'hf, epc_pkg::PR_TCP,
            16'd80, 16'd1, 58, 1'b0, epc_pkg::CLS_ARP, '0, '0, '0));
        directed_rows.push_back(frame_row(epc_pkg::ETH_IPV6, 4'd0, epc_pkg::PR_UDP,
            16'd53, 16'd53, 58, 1'b0, epc_pkg::CLS_ARP, '0, '0, '0));
        directed_rows.push_back(frame_row(epc_pkg::ETH_IPV6, 4'd0, 8'h00,
            16'd0, 16'd0, 21, 1'b0, epc_pkg::CLS_ARP, '0, '0, '0));
        directed_rows.push_back(frame_row(epc_pkg::ETH_IPV6, 4'd0, epc_pkg::PR_UDP,
            16'd0, 16'd0, 20, 1'b1, epc_pkg::CLS_TRUNC, epc_pkg::ETH_IPV6, 32'd18, 32'd0));
        directed_rows.push_back(frame_row(16'h8100, 4'd0, 8'h00, 16'd0, 16'd0, 20,
            1'b0, epc_pkg::CLS_ARP, '0, '0, '0));
        directed_rows.push_back(frame_row(16'hffff, 4'd0, 8'h00, 16'd0, 16'd0, 14,
            1'b1, epc_pkg::CLS_OTHER, 16'hffff, 32'd20, 32'd2));
        directed_rows.push_back(frame_row(16'h0000, 4'd0, 8'h00, 16'd0, 16'd0, 14,
            1'b0, epc_pkg::CLS_ARP, '0, '0, '0));
        directed_rows.push_back(frame_row(epc_pkg::ETH_IPV6, 4'd0, epc_pkg::PR_TCP,
            16'd80, 16'd80, 57, 1'b0, epc_pkg::CLS_ARP, '0, '0, '0));

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < directed_rows.size(); i++)
            send_frame(directed_rows[i]);

        run_phase(34, 55, 16'h0000);
        run_phase(55, 34, 16'hffff);
        run_phase(0, 0, 16'($urandom));

        frame_in.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("covered %0d frames in %0d words, http port 80, 0, 65535 and random",
                 frames_seen, words_seen);
        $display("tallies: arp %0d icmp %0d icmpv6 %0d tcp %0d http %0d udp %0d",
                 frame_tally[epc_pkg::CLS_ARP], frame_tally[epc_pkg::CLS_ICMP],
                 frame_tally[epc_pkg::CLS_ICMP6], frame_tally[epc_pkg::CLS_TCP],
                 frame_tally[epc_pkg::CLS_HTTP], frame_tally[epc_pkg::CLS_UDP]);
        if (errors == 0 && pending_reports.size() == 0)
            $display("ethernet_packet_classifier verification clean");
        else
            $display("ethernet_packet_classifier verification failed");
        $finish;
    end
endmodule
